[design/crc_pkg.sv]
// ----------------------------------------------------------------------------
// crc_pkg
// Shared codes and types for the chained rational comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_pkg;

    typedef enum logic [2:0] {
        OP_EQ   = 3'd0,
        OP_DIFF = 3'd1,
        OP_LT   = 3'd2,
        OP_LE   = 3'd3,
        OP_GT   = 3'd4,
        OP_GE   = 3'd5,
        OP_ZERO = 3'd6,
        OP_NONE = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ARG_TYPE = 2'd1,
        ST_UNIMPL   = 2'd2
    } status_t;

    localparam logic [1:0] KIND_INT = 2'd0;
    localparam logic [1:0] KIND_RAT = 2'd1;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 5;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned NUM_W      = 32;
    localparam int unsigned DEN_W      = 31;

    // classification of one argument, handed from front to back
    typedef struct packed {
        logic    first;
        logic    pair_numeric;
        logic    cur_numeric;
        logic    num_zero;
        opcode_t op;
        logic    last;
    } flags_t;

endpackage

`default_nettype wire

[design/chained_rational_comparator.sv]
// ----------------------------------------------------------------------------
// chained_rational_comparator
// Compares the arguments of a call pairwise as exact rationals.
// ----------------------------------------------------------------------------
// Each argument arrives as one transaction on the s_ channel: tuser holds the
// opcode (read on the first argument of a call) and the type, tdata holds
// numerator and denominator, tlast marks the final argument. One result per
// call leaves on the m_ channel: the verdict and a status code.
// Throughput is one argument per cycle while s_tready is high. Each pair
// costs two products of VALUE_WIDTH bits by VALUE_WIDTH bits, registered,
// then one compare. The last argument of a call passes through the queue,
// the product register and the result register before the result is valid;
// a low m_tready can hold it in the latter two. A four-entry queue separates
// the classifying front from the arithmetic back; s_tready falls only when
// that queue is full, which can happen once a low m_tready holds the result
// register and a further call's last argument stalls in the product stage.
// Reset clears the call state, the queue and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_rational_comparator #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // numerator[31:0], denominator[62:32], zero
    input  wire logic [4:0]  s_tuser,   // opcode[2:0], arg_type[4:3]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // verdict[0], status[2:1], zero
);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned FLAGS_W     = $bits(crc_pkg::flags_t);
    localparam int unsigned ENTRY_W     = FLAGS_W + 4 * VALUE_WIDTH - 2;

    logic                          q_full;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_not_empty;
    crc_pkg::flags_t               wr_flags;
    logic signed [VALUE_WIDTH-1:0] wr_prev_num;
    logic [VALUE_WIDTH-2:0]        wr_prev_den;
    logic signed [VALUE_WIDTH-1:0] wr_cur_num;
    logic [VALUE_WIDTH-2:0]        wr_cur_den;
    logic [ENTRY_W-1:0]            wr_entry;
    logic [ENTRY_W-1:0]            rd_entry;
    crc_pkg::flags_t               rd_flags;
    logic signed [VALUE_WIDTH-1:0] rd_prev_num;
    logic [VALUE_WIDTH-2:0]        rd_prev_den;
    logic signed [VALUE_WIDTH-1:0] rd_cur_num;
    logic [VALUE_WIDTH-2:0]        rd_cur_den;

    crc_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_flags    (wr_flags),
        .q_prev_num (wr_prev_num),
        .q_prev_den (wr_prev_den),
        .q_cur_num  (wr_cur_num),
        .q_cur_den  (wr_cur_den)
    );

    assign wr_entry = {wr_flags, wr_prev_num, wr_prev_den, wr_cur_num, wr_cur_den};

    crc_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (wr_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (rd_entry)
    );

    assign {rd_flags, rd_prev_num, rd_prev_den, rd_cur_num, rd_cur_den} = rd_entry;

    crc_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_flags     (rd_flags),
        .q_prev_num  (rd_prev_num),
        .q_prev_den  (rd_prev_den),
        .q_cur_num   (rd_cur_num),
        .q_cur_den   (rd_cur_den),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

[design/crc_front.sv]
// ----------------------------------------------------------------------------
// crc_front
// Accepts arguments, narrows and classifies them and pairs each with the
// previous argument of the same call.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_front #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [crc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [crc_pkg::IN_USER_W-1:0]    s_tuser,
    input  wire logic                             s_tlast,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output crc_pkg::flags_t                       q_flags,
    output logic signed [VALUE_WIDTH-1:0]         q_prev_num,
    output logic [VALUE_WIDTH-2:0]                q_prev_den,
    output logic signed [VALUE_WIDTH-1:0]         q_cur_num,
    output logic [VALUE_WIDTH-2:0]                q_cur_den
);

    localparam logic [VALUE_WIDTH-2:0] DEN_ONE = {{(VALUE_WIDTH-2){1'b0}}, 1'b1};

    logic                          have_prev_reg, have_prev_next;
    logic                          prev_numeric_reg, prev_numeric_next;
    logic signed [VALUE_WIDTH-1:0] prev_num_reg, prev_num_next;
    logic [VALUE_WIDTH-2:0]        prev_den_reg, prev_den_next;

    logic [1:0]                    kind;
    logic                          numeric;
    logic signed [VALUE_WIDTH-1:0] num;
    logic [VALUE_WIDTH-2:0]        den;
    logic                          accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        kind    = s_tuser[4:3];
        numeric = (kind == crc_pkg::KIND_INT) || (kind == crc_pkg::KIND_RAT);
        num     = s_tdata[VALUE_WIDTH-1:0];
        den     = (kind == crc_pkg::KIND_INT) ? DEN_ONE
                                              : s_tdata[crc_pkg::NUM_W +: (VALUE_WIDTH-1)];
    end

    always_comb begin
        q_push               = accept;
        q_flags.first        = !have_prev_reg;
        q_flags.pair_numeric = prev_numeric_reg && numeric;
        q_flags.cur_numeric  = numeric;
        q_flags.num_zero     = (num == '0);
        q_flags.op           = crc_pkg::opcode_t'(s_tuser[2:0]);
        q_flags.last         = s_tlast;
        q_prev_num           = prev_num_reg;
        q_prev_den           = prev_den_reg;
        q_cur_num            = num;
        q_cur_den            = den;
    end

    always_comb begin
        have_prev_next    = have_prev_reg;
        prev_numeric_next = prev_numeric_reg;
        prev_num_next     = prev_num_reg;
        prev_den_next     = prev_den_reg;
        if (accept) begin
            have_prev_next    = !s_tlast;
            prev_numeric_next = numeric;
            prev_num_next     = num;
            prev_den_next     = den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg    <= 1'b0;
            prev_numeric_reg <= 1'b1;
        end else begin
            have_prev_reg    <= have_prev_next;
            prev_numeric_reg <= prev_numeric_next;
        end
        prev_num_reg <= prev_num_next;
        prev_den_reg <= prev_den_next;
    end

endmodule

`default_nettype wire

[design/crc_fifo.sv]
// ----------------------------------------------------------------------------
// crc_fifo
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_fifo #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/crc_back.sv]
// ----------------------------------------------------------------------------
// crc_back
// Cross-multiplies each pair, applies the held operation to the call state
// and registers one result per call.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_back #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 q_not_empty,
    output logic                                      q_pop,
    input  wire crc_pkg::flags_t                      q_flags,
    input  wire logic signed [VALUE_WIDTH-1:0]        q_prev_num,
    input  wire logic [VALUE_WIDTH-2:0]               q_prev_den,
    input  wire logic signed [VALUE_WIDTH-1:0]        q_cur_num,
    input  wire logic [VALUE_WIDTH-2:0]               q_cur_den,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [crc_pkg::OUT_DATA_W-1:0]            m_tdata
);

    localparam int unsigned PROD_W = 2 * VALUE_WIDTH;

    // product stage
    logic                     prod_valid_reg, prod_valid_next;
    crc_pkg::flags_t          prod_flags_reg;
    logic signed [PROD_W-1:0] lhs_reg, rhs_reg;
    logic signed [PROD_W-1:0] lhs_next, rhs_next;

    // call state
    crc_pkg::opcode_t         held_op_reg, held_op_next;
    logic                     decided_reg, decided_next;
    logic                     verdict_reg, verdict_next;
    crc_pkg::status_t         status_reg, status_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_verdict_reg, out_verdict_next;
    crc_pkg::status_t         out_status_reg, out_status_next;

    logic                     out_free;
    logic                     decide_fire;
    logic                     prod_ready;
    logic                     fin;
    logic                     fin_verdict;
    crc_pkg::status_t         fin_status;
    logic                     pass;

    assign out_free    = !out_valid_reg || m_tready;
    assign decide_fire = prod_valid_reg && (!prod_flags_reg.last || out_free);
    assign prod_ready  = !prod_valid_reg || decide_fire;
    assign q_pop       = q_not_empty && prod_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(crc_pkg::OUT_DATA_W-3){1'b0}}, out_status_reg, out_verdict_reg};

    always_comb begin
        lhs_next        = q_prev_num * $signed({1'b0, q_cur_den});
        rhs_next        = q_cur_num * $signed({1'b0, q_prev_den});
        prod_valid_next = prod_valid_reg;
        if (prod_ready) begin
            prod_valid_next = q_not_empty;
        end
    end

    always_comb begin
        fin         = 1'b0;
        fin_verdict = 1'b0;
        fin_status  = crc_pkg::ST_OK;
        case (held_op_reg)
            crc_pkg::OP_EQ:   pass = (lhs_reg == rhs_reg);
            crc_pkg::OP_DIFF: pass = (lhs_reg != rhs_reg);
            crc_pkg::OP_LT:   pass = (lhs_reg <  rhs_reg);
            crc_pkg::OP_LE:   pass = (lhs_reg <= rhs_reg);
            crc_pkg::OP_GT:   pass = (lhs_reg >  rhs_reg);
            default:          pass = (lhs_reg >= rhs_reg);
        endcase
        if (prod_flags_reg.first) begin
            if (prod_flags_reg.op == crc_pkg::OP_ZERO) begin
                fin = 1'b1;
                if (prod_flags_reg.cur_numeric) begin
                    fin_verdict = prod_flags_reg.num_zero;
                end else begin
                    fin_status = crc_pkg::ST_UNIMPL;
                end
            end else if (prod_flags_reg.op == crc_pkg::OP_NONE) begin
                fin        = 1'b1;
                fin_status = crc_pkg::ST_UNIMPL;
            end
        end else if (!decided_reg) begin
            if (!prod_flags_reg.pair_numeric) begin
                fin = 1'b1;
                if (held_op_reg != crc_pkg::OP_EQ && held_op_reg != crc_pkg::OP_DIFF) begin
                    fin_status = crc_pkg::ST_ARG_TYPE;
                end
            end else if (!pass) begin
                fin = 1'b1;
            end
        end
    end

    always_comb begin
        held_op_next     = held_op_reg;
        decided_next     = decided_reg;
        verdict_next     = verdict_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_verdict_next = out_verdict_reg;
        out_status_next  = out_status_reg;
        if (decide_fire) begin
            if (prod_flags_reg.first) begin
                held_op_next = prod_flags_reg.op;
            end
            if (fin) begin
                decided_next = 1'b1;
                verdict_next = fin_verdict;
                status_next  = fin_status;
            end
            if (prod_flags_reg.last) begin
                out_valid_next   = 1'b1;
                out_verdict_next = (status_next == crc_pkg::ST_OK) && verdict_next;
                out_status_next  = status_next;
                held_op_next     = crc_pkg::OP_EQ;
                decided_next     = 1'b0;
                verdict_next     = 1'b1;
                status_next      = crc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            held_op_reg    <= crc_pkg::OP_EQ;
            decided_reg    <= 1'b0;
            verdict_reg    <= 1'b1;
            status_reg     <= crc_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            held_op_reg    <= held_op_next;
            decided_reg    <= decided_next;
            verdict_reg    <= verdict_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
        if (q_pop) begin
            prod_flags_reg <= q_flags;
            lhs_reg        <= lhs_next;
            rhs_reg        <= rhs_next;
        end
        out_verdict_reg <= out_verdict_next;
        out_status_reg  <= out_status_next;
    end

endmodule

`default_nettype wire

[design/crc_checker.sv]
// ----------------------------------------------------------------------------
// crc_checker
// Port-level checks on the result channel of the comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_verdict_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'd0)
        else $error("true verdict with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
        else $error("undefined status or padding set");

endmodule

bind chained_rational_comparator crc_checker u_crc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained rational comparator.
// ----------------------------------------------------------------------------
// Arguments are queued up front, directed calls first and then random calls.
// Most random calls are chains built to satisfy their opcode, so that they run
// deep; the rest mix in junk types and raw field values. A clocked driver
// offers them on the s_ channel, and a clocked monitor takes results off the
// m_ channel. Every accepted argument goes through a local model of the call
// state, which queues the verdict and status due on each final argument.
// Both sides idle at random, apart from one calm stretch. The receiver holds
// off once for long enough to back up the input, and the sender once waits
// for every outstanding result before it goes on.
// ----------------------------------------------------------------------------

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int TARGET_ARGS = 450;
    localparam int DRAIN_AT    = 300;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 90;
    localparam int CALM_FROM   = 200;
    localparam int CALM_TO     = 290;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        crc_pkg::opcode_t op;
        logic [1:0]       kind;
        logic [31:0]      num;
        logic [30:0]      den;
        logic             last;
        bit               drain_first;
    } arg_item_t;

    typedef struct {
        logic             verdict;
        crc_pkg::status_t status;
    } verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // numerator[31:0], denominator[62:32], zero
    logic [4:0]  s_tuser  = '0;    // opcode[2:0], arg_type[4:3]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // verdict[0], status[2:1], zero

    arg_item_t arg_queue[$];
    verdict_t  expected_verdicts[$];
    arg_item_t cur_arg;

    // call state of the local model
    longint           prev_num;
    longint           prev_den;
    logic [1:0]       prev_kind;
    bit               have_prev;
    bit               decided;
    bit               run_verdict;
    crc_pkg::status_t pend_status;
    crc_pkg::opcode_t held_op;

    int n_queued = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_true = 0;
    int status_seen[3];
    int op_calls[8];
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit drain_next = 1'b0;
    bit drain_done = 1'b0;
    int quiet_cycles = 0;

    chained_rational_comparator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic bit is_number(logic [1:0] k);
        return k == crc_pkg::KIND_INT || k == crc_pkg::KIND_RAT;
    endfunction

    function automatic bit no_idling();
        return n_sent >= CALM_FROM && n_sent < CALM_TO;
    endfunction

    function automatic void clear_call();
        prev_num    = 0;
        prev_den    = 1;
        prev_kind   = crc_pkg::KIND_INT;
        have_prev   = 1'b0;
        decided     = 1'b0;
        run_verdict = 1'b1;
        pend_status = crc_pkg::ST_OK;
        held_op     = crc_pkg::OP_EQ;
    endfunction

    function automatic void settle(bit v, crc_pkg::status_t s);
        decided     = 1'b1;
        run_verdict = v;
        pend_status = s;
    endfunction

    function automatic void absorb_argument(arg_item_t a);
        longint num, den, lhs, rhs;
        bit holds;
        num = longint'($signed(a.num));
        if (a.kind == crc_pkg::KIND_INT) begin
            den = 1;
        end else begin
            den = longint'({1'b0, a.den});
        end
        if (!have_prev) begin
            held_op = a.op;
            op_calls[a.op]++;
            if (a.op == crc_pkg::OP_ZERO) begin
                if (is_number(a.kind)) begin
                    settle(num == 0, crc_pkg::ST_OK);
                end else begin
                    settle(1'b0, crc_pkg::ST_UNIMPL);
                end
            end else if (a.op == crc_pkg::OP_NONE) begin
                settle(1'b0, crc_pkg::ST_UNIMPL);
            end
        end else if (!decided) begin
            if (!is_number(prev_kind) || !is_number(a.kind)) begin
                if (held_op == crc_pkg::OP_EQ || held_op == crc_pkg::OP_DIFF) begin
                    settle(1'b0, crc_pkg::ST_OK);
                end else begin
                    settle(1'b0, crc_pkg::ST_ARG_TYPE);
                end
            end else begin
                lhs = prev_num * den;
                rhs = num * prev_den;
                case (held_op)
                    crc_pkg::OP_EQ:   holds = lhs == rhs;
                    crc_pkg::OP_DIFF: holds = lhs != rhs;
                    crc_pkg::OP_LT:   holds = lhs < rhs;
                    crc_pkg::OP_LE:   holds = lhs <= rhs;
                    crc_pkg::OP_GT:   holds = lhs > rhs;
                    default:          holds = lhs >= rhs;
                endcase
                if (!holds) begin
                    settle(1'b0, crc_pkg::ST_OK);
                end
            end
        end
        prev_num  = num;
        prev_den  = den;
        prev_kind = a.kind;
        have_prev = 1'b1;
        if (a.last) begin
            expected_verdicts.push_back(
                '{verdict: pend_status == crc_pkg::ST_OK && run_verdict,
                  status: pend_status});
            clear_call();
        end
    endfunction

    task automatic queue_arg(crc_pkg::opcode_t op, logic [1:0] kind, logic [31:0] num,
                             logic [30:0] den, logic last);
        arg_queue.push_back('{op: op, kind: kind, num: num, den: den, last: last,
                              drain_first: drain_next});
        drain_next = 1'b0;
        n_queued++;
    endtask

    // build a chain that mostly satisfies its opcode, or a junk call
    task automatic queue_random_call();
        int unsigned len, k;
        crc_pkg::opcode_t op;
        longint n, d, step;
        bit tidy, wide;
        logic [1:0] kind;
        logic [30:0] den_field;
        len  = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        op   = crc_pkg::opcode_t'(($urandom_range(9) == 0) ? $urandom_range(7, 6)
                                                           : $urandom_range(5, 0));
        tidy = $urandom_range(99) < 75;
        wide = 1'b0;
        case ($urandom_range(2))
            0: begin
                n = longint'($urandom_range(16)) - 8;
                d = longint'($urandom_range(4, 1));
            end
            1: begin
                n = longint'($signed($urandom())) >>> 1;
                d = 1;
                wide = 1'b1;
            end
            default: begin
                n = longint'($signed($urandom())) >>> 1;
                d = longint'($urandom_range(32'h7FFF_FFFF, 1));
                wide = 1'b1;
            end
        endcase
        if (op == crc_pkg::OP_ZERO && $urandom_range(1) == 1) begin
            n = 0;
        end
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                k = (!wide && d < 1000) ? $urandom_range(3, 1) : 1;
                d = d * k;
                n = n * k;
                step = wide ? longint'($urandom_range(1000, 1))
                            : longint'($urandom_range(3, 1));
                case (op)
                    crc_pkg::OP_EQ:   step = 0;
                    crc_pkg::OP_LT:   step = step;
                    crc_pkg::OP_LE:   step = ($urandom_range(1) == 1) ? step : 0;
                    crc_pkg::OP_GT:   step = -step;
                    crc_pkg::OP_GE:   step = ($urandom_range(1) == 1) ? -step : 0;
                    default:          step = ($urandom_range(1) == 1) ? step : -step;
                endcase
                n = n + step;
            end
            kind = (d == 1 && $urandom_range(1) == 1) ? crc_pkg::KIND_INT
                                                      : crc_pkg::KIND_RAT;
            den_field = (kind == crc_pkg::KIND_INT) ? 31'($urandom()) : d[30:0];
            if (!tidy && $urandom_range(2) == 0) begin
                queue_arg(i == 0 ? op : crc_pkg::opcode_t'($urandom_range(7)),
                          2'($urandom_range(3)), $urandom(), 31'($urandom()),
                          i == len - 1);
            end else begin
                queue_arg(i == 0 ? op : crc_pkg::opcode_t'($urandom_range(7)),
                          kind, n[31:0], den_field, i == len - 1);
            end
        end
    endtask

    task automatic report_mismatch(string what);
        n_errors++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    initial begin
        clear_call();
        // single integer, zero tests, undefined opcode, lone junk argument
        queue_arg(crc_pkg::OP_EQ, crc_pkg::KIND_INT, 32'd0, 31'h7FFF_FFFF, 1'b1);
        queue_arg(crc_pkg::OP_ZERO, crc_pkg::KIND_INT, 32'd0, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_ZERO, crc_pkg::KIND_RAT, 32'd0, 31'd7, 1'b0);
        queue_arg(crc_pkg::OP_EQ, KIND_OTHER, 32'd9, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_ZERO, KIND_SPARE, 32'd0, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_NONE, crc_pkg::KIND_INT, 32'd1, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_LT, KIND_OTHER, 32'd5, 31'd1, 1'b1);
        // equal across types, junk pair member on eq/diff and on ordering
        queue_arg(crc_pkg::OP_EQ, crc_pkg::KIND_INT, 32'd3, 31'd0, 1'b0);
        queue_arg(crc_pkg::OP_EQ, crc_pkg::KIND_RAT, 32'd6, 31'd2, 1'b1);
        queue_arg(crc_pkg::OP_DIFF, crc_pkg::KIND_INT, 32'd1, 31'd1, 1'b0);
        queue_arg(crc_pkg::OP_DIFF, KIND_OTHER, 32'd2, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_LT, crc_pkg::KIND_RAT, 32'd1, 31'd2, 1'b0);
        queue_arg(crc_pkg::OP_LT, KIND_SPARE, 32'd3, 31'd1, 1'b1);
        // extremes of numerator and denominator
        queue_arg(crc_pkg::OP_LT, crc_pkg::KIND_RAT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
        queue_arg(crc_pkg::OP_LT, crc_pkg::KIND_RAT, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        queue_arg(crc_pkg::OP_LT, crc_pkg::KIND_INT, 32'd2, 31'h7FFF_FFFF, 1'b1);
        // zero denominators
        queue_arg(crc_pkg::OP_GE, crc_pkg::KIND_RAT, 32'd5, 31'd0, 1'b0);
        queue_arg(crc_pkg::OP_GE, crc_pkg::KIND_RAT, 32'd3, 31'd0, 1'b1);
        // early false pair, later junk ignored, negative rational against zero
        queue_arg(crc_pkg::OP_GT, crc_pkg::KIND_INT, 32'd1, 31'd1, 1'b0);
        queue_arg(crc_pkg::OP_GT, crc_pkg::KIND_INT, 32'd2, 31'd1, 1'b0);
        queue_arg(crc_pkg::OP_GT, KIND_OTHER, 32'd0, 31'd1, 1'b1);
        queue_arg(crc_pkg::OP_LE, crc_pkg::KIND_RAT, 32'hFFFF_FFFF, 31'd3, 1'b0);
        queue_arg(crc_pkg::OP_LE, crc_pkg::KIND_INT, 32'd0, 31'd5, 1'b1);
        while (n_queued < TARGET_ARGS) begin
            if (!drain_done && n_queued >= DRAIN_AT) begin
                drain_next = 1'b1;
                drain_done = 1'b1;
            end
            queue_random_call();
        end

        wait (n_sent == n_queued);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d arguments in %0d calls: %0d true, %0d ok-false,",
                 n_sent, n_results, n_true, status_seen[crc_pkg::ST_OK] - n_true);
        $display("%0d type errors, %0d unimplemented; calls per opcode %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[crc_pkg::ST_ARG_TYPE], status_seen[crc_pkg::ST_UNIMPL],
                 op_calls[0], op_calls[1], op_calls[2], op_calls[3],
                 op_calls[4], op_calls[5], op_calls[6], op_calls[7]);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // driver: advance to the next argument once the current one is taken
    always @(posedge aclk) begin
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_argument(cur_arg);
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (arg_queue.size() != 0
                    && (!arg_queue[0].drain_first || expected_verdicts.size() == 0)
                    && (hold_left != 0 || no_idling() || $urandom_range(99) >= 24)) begin
                    cur_arg = arg_queue.pop_front();
                    s_tdata <= {1'b0, cur_arg.den, cur_arg.num};
                    s_tuser <= {cur_arg.kind, cur_arg.op};
                    s_tlast <= cur_arg.last;
                    offer = 1'b1;
                end
                s_tvalid <= offer;
            end
        end
    end

    // monitor: check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tdata[2:1] < 2'd3) begin
                    status_seen[m_tdata[2:1]]++;
                end
                if (m_tdata[0]) begin
                    n_true++;
                end
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result 0x%02h", m_tdata));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.verdict) begin
                        report_mismatch($sformatf("call %0d verdict %b, want %b",
                                                  n_results, m_tdata[0], want.verdict));
                    end
                    if (m_tdata[2:1] !== want.status) begin
                        report_mismatch($sformatf("call %0d status %0d, want %s",
                                                  n_results, m_tdata[2:1],
                                                  want.status.name()));
                    end
                end
            end
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idling() || $urandom_range(99) >= 24;
            end
        end
    end

    // drop out if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[filelist.f]
design/crc_pkg.sv
design/crc_front.sv
design/crc_fifo.sv
design/crc_back.sv
design/chained_rational_comparator.sv
design/crc_checker.sv
tb/sv/tb.sv
